// ===== hdl/bitmap_block_allocator_macros.svh =====
// Assertion macros of the bitmap block allocator checker.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Clocked assertion, quiet while reset is asserted
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds across reset
`define BBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/bba_pkg.sv =====
// Shared types, constants and helper functions of the bitmap block allocator.
package bba_pkg;

  // free-map word geometry
  localparam int WORD_W = 64;
  localparam int BIT_W  = 6;
  // unit offsets (run ends and aligned jumps stay below 2^18)
  localparam int OFF_W  = 18;
  localparam int WI_W   = OFF_W - BIT_W;

  // field widths
  localparam int SIZE_W = 13;
  localparam int ADDR_W = 17;
  localparam int BASE_W = 16;
  localparam int CIDX_W = 2;

  // unit count is kept in whole bytes of the map
  localparam logic [SIZE_W-1:0] UNITS_MASK = 13'h1FF8;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [OFF_W-1:0]  off_t;
  typedef logic [WI_W-1:0]   widx_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_MAP_BASE     = 2'd0,
    CFG_MAP_UNITS    = 2'd1,
    CFG_POWERED_DOWN = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic {
    STS_OK     = 1'b0,
    STS_NO_MEM = 1'b1
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_SEARCH,
    ST_UPDATE
  } state_t;

  // highest set bit as a one-hot value; zero counts as one
  function automatic logic [SIZE_W-1:0] top_bit(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] p;
    p = SIZE_W'(1);
    for (int i = 0; i < SIZE_W; i++) begin
      if (v[i]) p = SIZE_W'(1) << i;
    end
    return p;
  endfunction

  // index of the highest set bit of a map word
  function automatic logic [BIT_W-1:0] msb_index(input word_t v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  // ones from bit lo up to bit hi, inclusive
  function automatic word_t win_mask(input logic [BIT_W-1:0] lo, input logic [BIT_W-1:0] hi);
    word_t m;
    m = ({WORD_W{1'b1}} << lo) & ({WORD_W{1'b1}} >> (~hi));
    return m;
  endfunction

endpackage

// ===== hdl/bitmap_block_allocator.sv =====
// Top level of the bitmap block allocator: first-fit runs in a free map RAM.
//
//   channel  | ports                                     | handshake
//   ---------+-------------------------------------------+--------------------------
//   request  | in_action in_block_units in_alignment     | start high, busy low
//            | in_free_address                           |
//   result   | out_status out_block_address              | out_valid, one cycle
//   config   | cfg_index cfg_wdata                       | cfg_we, no wait
//
// After an accept a prep step checks the word; a free then writes each map word it
//   touches, and an allocate takes search steps (a word read that moves on, jumps to a
//   later aligned candidate or ends) and then writes each map word of the run found;
//   busy falls with the strobe. After reset a clearing pass fills the map; busy is
//   high meanwhile and config writes are still taken.
// The receiver cannot stall: each result is shown for exactly one cycle.
module bitmap_block_allocator #(
  parameter int MAP_UNITS = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_action,
  input  logic [bba_pkg::SIZE_W-1:0]  in_block_units,
  input  logic [bba_pkg::SIZE_W-1:0]  in_alignment,
  input  logic [bba_pkg::ADDR_W-1:0]  in_free_address,
  // result
  output logic                        out_valid,
  output logic                        out_status,
  output logic [bba_pkg::ADDR_W-1:0]  out_block_address,
  // configuration
  input  logic                        cfg_we,
  input  logic [bba_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [bba_pkg::BASE_W-1:0]  cfg_wdata
);

  import bba_pkg::*;

  localparam int DEPTH  = (MAP_UNITS + WORD_W - 1) / WORD_W;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SOFF_W = OFF_W + 1;

  // control state
  state_t               state_r, state_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  off_t                 j_r, j_nxt;
  widx_t                w_r, w_nxt;
  off_t                 lo_r, lo_nxt;
  off_t                 hi_r, hi_nxt;
  logic                 set_r, set_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]    out_addr_r, out_addr_nxt;

  // configuration registers
  logic [BASE_W-1:0]    map_base_r;
  logic [SIZE_W-1:0]    map_units_r;
  logic                 powered_down_r;

  // request word
  action_t              act_r;
  logic [SIZE_W-1:0]    size_r;
  logic [SIZE_W-1:0]    atop_r;
  logic [ADDR_W-1:0]    faddr_r;

  // RAM port
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  word_t                ram_wdata;
  word_t                ram_rdata;

  logic                 accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // managed unit count: multiple of eight, capped at the map size
  logic [SIZE_W-1:0]    units_raw;
  off_t                 units;
  assign units_raw = map_units_r & UNITS_MASK;
  assign units = (off_t'(units_raw) > off_t'(MAP_UNITS)) ? off_t'(MAP_UNITS)
                                                         : off_t'(units_raw);

  // alignment mask and first aligned offset
  logic [SIZE_W-1:0]    amask13;
  logic [BASE_W-1:0]    neg_base;
  logic [SIZE_W-1:0]    r_first;
  off_t                 amask;
  off_t                 r_ext;
  assign amask13  = atop_r - SIZE_W'(1);
  assign neg_base = BASE_W'(0) - map_base_r;
  assign r_first  = neg_base[SIZE_W-1:0] & amask13;
  assign amask    = off_t'(amask13);
  assign r_ext    = off_t'(r_first);

  // search: window of the current candidate inside the word in hand
  off_t                 s_sum, s_end, k_pos, j_new;
  widx_t                s_jw, s_ew;
  logic                 s_fit;
  logic [BIT_W-1:0]     s_lo, s_hi;
  word_t                s_used;
  assign s_sum  = j_r + off_t'(size_r);
  assign s_end  = s_sum - off_t'(1);
  assign s_fit  = (s_sum <= units);
  assign s_jw   = j_r[OFF_W-1:BIT_W];
  assign s_ew   = s_end[OFF_W-1:BIT_W];
  assign s_lo   = (w_r == s_jw) ? j_r[BIT_W-1:0] : '0;
  assign s_hi   = (w_r == s_ew) ? s_end[BIT_W-1:0] : '1;
  assign s_used = ~ram_rdata & win_mask(s_lo, s_hi);
  // next aligned candidate past the highest used unit in the window
  assign k_pos  = {w_r, msb_index(s_used)};
  assign j_new  = (((k_pos - r_ext) | amask) + off_t'(1)) + r_ext;

  // update: bits of the run inside the word in hand
  off_t                 u_last;
  widx_t                u_lw, u_hw;
  logic [BIT_W-1:0]     u_lo, u_hi;
  word_t                u_mask;
  assign u_last = hi_r - off_t'(1);
  assign u_lw   = lo_r[OFF_W-1:BIT_W];
  assign u_hw   = u_last[OFF_W-1:BIT_W];
  assign u_lo   = (w_r == u_lw) ? lo_r[BIT_W-1:0] : '0;
  assign u_hi   = (w_r == u_hw) ? u_last[BIT_W-1:0] : '1;
  assign u_mask = win_mask(u_lo, u_hi);

  // free: clip the released run to the managed units
  logic signed [SOFF_W-1:0] f_off, f_end, f_lo, f_hi, f_units;
  logic                     f_hit;
  assign f_off   = $signed(SOFF_W'(faddr_r)) - $signed(SOFF_W'(map_base_r));
  assign f_end   = f_off + $signed(SOFF_W'(size_r));
  assign f_units = $signed(SOFF_W'(units));
  assign f_lo    = f_off[SOFF_W-1] ? '0 : f_off;
  assign f_hi    = (f_end > f_units) ? f_units : f_end;
  assign f_hit   = (f_hi > f_lo);

  // next state, RAM access and result
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    j_nxt          = j_r;
    w_nxt          = w_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    set_nxt        = set_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    ram_we         = 1'b0;
    ram_waddr      = w_r[AW-1:0];
    ram_wdata      = ram_rdata;
    unique case (state_r)
      ST_CLEAR: begin
        // all free, except the reserved null unit
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = (clr_r == '0) ? ~word_t'(1) : '1;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        if (act_r == ACT_ALLOC) begin
          if (powered_down_r || (size_r == '0)) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STS_NO_MEM;
            out_addr_nxt   = '0;
            state_nxt      = ST_IDLE;
          end else begin
            j_nxt     = r_ext;
            w_nxt     = r_ext[OFF_W-1:BIT_W];
            state_nxt = ST_SEARCH;
          end
        end else begin
          if ((faddr_r == '0) || !f_hit) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STS_OK;
            out_addr_nxt   = '0;
            state_nxt      = ST_IDLE;
          end else begin
            lo_nxt    = f_lo[OFF_W-1:0];
            hi_nxt    = f_hi[OFF_W-1:0];
            set_nxt   = 1'b1;
            w_nxt     = f_lo[OFF_W-1:BIT_W];
            state_nxt = ST_UPDATE;
          end
        end
      end
      ST_SEARCH: begin
        priority if (!s_fit) begin
          // candidate runs past the last managed unit
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_NO_MEM;
          out_addr_nxt   = '0;
          state_nxt      = ST_IDLE;
        end else if (s_used != '0) begin
          j_nxt = j_new;
          w_nxt = j_new[OFF_W-1:BIT_W];
        end else if (w_r == s_ew) begin
          // whole run free: go back and mark it used
          lo_nxt    = j_r;
          hi_nxt    = s_sum;
          set_nxt   = 1'b0;
          w_nxt     = s_jw;
          state_nxt = ST_UPDATE;
        end else begin
          w_nxt = w_r + widx_t'(1);
        end
      end
      ST_UPDATE: begin
        ram_we    = 1'b1;
        ram_waddr = w_r[AW-1:0];
        ram_wdata = set_r ? (ram_rdata | u_mask) : (ram_rdata & ~u_mask);
        if (w_r == u_hw) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_OK;
          out_addr_nxt   = set_r ? '0 : ADDR_W'(off_t'(map_base_r) + lo_r);
          state_nxt      = ST_IDLE;
        end else begin
          w_nxt = w_r + widx_t'(1);
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= STS_OK;
      out_addr_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_addr_r   <= out_addr_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_base_r     <= '0;
      map_units_r    <= SIZE_W'(4096);
      powered_down_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAP_BASE:     map_base_r     <= cfg_wdata;
        CFG_MAP_UNITS:    map_units_r    <= cfg_wdata[SIZE_W-1:0];
        CFG_POWERED_DOWN: powered_down_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // request word and scan pointers
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r   <= action_t'(in_action);
      size_r  <= in_block_units;
      atop_r  <= top_bit(in_alignment);
      faddr_r <= in_free_address;
    end
    j_r   <= j_nxt;
    w_r   <= w_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    set_r <= set_nxt;
  end

  // free map: read the word needed next cycle, write back the one in hand
  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (w_nxt[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_address = out_addr_r;

endmodule

// ===== hdl/bba_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/bba_checker.sv =====
// Port-level checker of the bitmap block allocator and its bind.
`include "bitmap_block_allocator_macros.svh"

module bba_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic                       out_status,
  input logic [bba_pkg::ADDR_W-1:0] out_block_address
);

  import bba_pkg::*;

  // reset starts the map clearing pass
  `BBA_ASSERT_ALWAYS(a_reset_busy, !rst_n |=> busy, "not busy after reset")

  // an accepted word keeps the block busy
  `BBA_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word did not set busy")

  // a result only ends a busy period, and never two in a row
  `BBA_ASSERT(a_result_after_work, out_valid |-> $past(busy), "result without work")
  `BBA_ASSERT(a_result_single, out_valid |=> !out_valid, "back-to-back results")

  // a failed allocation reports the null address
  `BBA_ASSERT(a_fail_null, (out_valid && (out_status == STS_NO_MEM)) |-> (out_block_address == '0),
              "failure with nonzero address")

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);

// ===== tb/tb.sv =====
// Testbench for the bitmap block allocator: free-map tracker, request driver and reply monitor.
`timescale 1ns / 100ps

module tb;
  import bba_pkg::*;

  localparam int MAP_DEPTH = 4096;
  localparam int LIVE_CAP  = 48;

  typedef struct {
    logic [0:0]        status;
    logic [ADDR_W-1:0] addr;
  } reply_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] units;
  } live_t;

  // Mirror of the free map and registers; predicts one reply per accepted word
  class free_map_tracker;
    bit          unit_free [MAP_DEPTH];
    int unsigned base_reg;
    int unsigned units_reg;
    bit          pd_reg;
    reply_t      pending_replies [$];
    int          mismatches;

    function void reset_state();
      foreach (unit_free[u]) unit_free[u] = 1'b1;
      unit_free[0] = 1'b0;
      base_reg  = 0;
      units_reg = MAP_DEPTH;
      pd_reg    = 1'b0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [BASE_W-1:0] data);
      case (idx)
        CFG_MAP_BASE:     base_reg  = data;
        CFG_MAP_UNITS:    units_reg = data & 16'h1FFF;
        CFG_POWERED_DOWN: pd_reg    = data[0];
        default: ;
      endcase
    endfunction

    // managed units: low three bits dropped, capped at the map depth
    function int unsigned span();
      int unsigned n;
      n = units_reg & ~32'd7;
      if (n > MAP_DEPTH) n = MAP_DEPTH;
      return n;
    endfunction

    // first-fit search over aligned absolute addresses
    function bit take_run(int unsigned size, logic [SIZE_W-1:0] align_in,
                          output logic [ADDR_W-1:0] addr);
      int unsigned n, a, i, k, stop;
      n = span();
      a = 1;
      addr = '0;
      for (int b = 0; b < SIZE_W; b++) begin
        if (align_in[b]) a = 32'd1 << b;
      end
      i = ((base_reg + a - 1) & ~(a - 1)) - base_reg;
      if (pd_reg || size == 0) return 1'b0;
      while (i < n && size <= n - i) begin
        stop = i + size;
        k = i;
        while (k < stop && unit_free[k]) k++;
        if (k == stop) begin
          for (int unsigned u = i; u < stop; u++) unit_free[u] = 1'b0;
          addr = ADDR_W'(base_reg + i);
          return 1'b1;
        end
        // hop to the first aligned offset past the used unit
        i += ((k + 1 - i + a - 1) / a) * a;
      end
      return 1'b0;
    endfunction

    // bits outside the managed range are dropped
    function void release_run(logic [ADDR_W-1:0] address, int size);
      int off, n;
      n = span();
      if (address == '0) return;
      off = int'(address) - int'(base_reg);
      for (int c = 0; c < size; c++) begin
        if (off + c >= 0 && off + c < n) unit_free[off + c] = 1'b1;
      end
    endfunction

    function reply_t log_request(action_t act, logic [SIZE_W-1:0] units,
                                 logic [SIZE_W-1:0] align, logic [ADDR_W-1:0] faddr);
      reply_t r;
      r.status = STS_OK;
      r.addr   = '0;
      if (act == ACT_ALLOC) begin
        if (!take_run(units, align, r.addr)) r.status = STS_NO_MEM;
      end else begin
        release_run(faddr, units);
      end
      pending_replies.push_back(r);
      return r;
    endfunction

    task report(string msg);
      if (mismatches < 100) $display("[%0t] ERROR %s", $time, msg);
      mismatches++;
    endtask

    task check_reply(logic status, logic [ADDR_W-1:0] addr);
      reply_t want;
      if (pending_replies.size() == 0) begin
        report($sformatf("reply with nothing pending: status %b addr %0h", status, addr));
        return;
      end
      want = pending_replies.pop_front();
      if (status !== want.status)
        report($sformatf("status %b, predicted %b", status, want.status));
      if (addr !== want.addr)
        report($sformatf("block_address %0h, predicted %0h", addr, want.addr));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_action;
  logic [SIZE_W-1:0] in_block_units;
  logic [SIZE_W-1:0] in_alignment;
  logic [ADDR_W-1:0] in_free_address;
  logic              out_valid;
  logic              out_status;
  logic [ADDR_W-1:0] out_block_address;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [BASE_W-1:0] cfg_wdata;

  free_map_tracker tracker;
  live_t           live_blocks [$];
  int              items_sent;

  bitmap_block_allocator #(.MAP_UNITS(MAP_DEPTH)) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_block_units    (in_block_units),
    .in_alignment      (in_alignment),
    .in_free_address   (in_free_address),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_block_address (out_block_address),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // reply monitor
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) tracker.check_reply(out_status, out_block_address);
  end

  // random sender gaps, none inside the quiet stretch
  task automatic idle_gap();
    int len;
    if ((items_sent >= 700 && items_sent < 1000) || $urandom_range(0, 99) >= 14) return;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 120) : $urandom_range(1, 6);
    start           <= 1'b0;
    in_action       <= 1'($urandom);
    in_block_units  <= SIZE_W'($urandom);
    in_alignment    <= SIZE_W'($urandom);
    in_free_address <= ADDR_W'($urandom);
    repeat (len) @(posedge clk);
  endtask

  // present one word and hold it until the block takes it
  task automatic send_word(action_t act, logic [SIZE_W-1:0] units,
                           logic [SIZE_W-1:0] align, logic [ADDR_W-1:0] faddr);
    reply_t r;
    start           <= 1'b1;
    in_action       <= act;
    in_block_units  <= units;
    in_alignment    <= align;
    in_free_address <= faddr;
    do @(posedge clk); while (busy !== 1'b0);
    r = tracker.log_request(act, units, align, faddr);
    if (act == ACT_ALLOC && r.status == STS_OK) live_blocks.push_back('{r.addr, units});
    items_sent++;
    idle_gap();
  endtask

  // wait for every reply and an idle block
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (tracker.pending_replies.size() != 0 || busy !== 1'b0);
  endtask

  task automatic write_settings(logic [BASE_W-1:0] base, logic [BASE_W-1:0] units,
                                logic [BASE_W-1:0] pd);
    cfg_idx_t          idx [3];
    logic [BASE_W-1:0] val [3];
    idx = '{CFG_MAP_BASE, CFG_MAP_UNITS, CFG_POWERED_DOWN};
    val = '{base, units, pd};
    for (int j = 0; j < 3; j++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[j];
      cfg_wdata <= val[j];
      @(posedge clk);
      tracker.write_reg(idx[j], val[j]);
    end
    cfg_we <= 1'b0;
  endtask

  // mostly allocate/free of live blocks, some malformed words
  task automatic random_item();
    int                r, idx;
    live_t             blk;
    logic [SIZE_W-1:0] size, align;
    logic [ADDR_W-1:0] junk;
    junk = ADDR_W'($urandom);
    r = $urandom_range(0, 99);
    if ((r < 50 && live_blocks.size() < LIVE_CAP) || (live_blocks.size() == 0 && r < 85)) begin
      case ($urandom_range(0, 19))
        0:          size = SIZE_W'($urandom_range(1025, 8191));
        1, 2:       size = SIZE_W'($urandom_range(129, 1024));
        3, 4, 5, 6: size = SIZE_W'($urandom_range(17, 128));
        default:    size = SIZE_W'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 19))
        0:                         align = SIZE_W'($urandom);
        1, 2:                      align = '0;
        3, 4, 5, 6, 7, 8, 9:       align = SIZE_W'(1) << $urandom_range(0, 12);
        default:                   align = SIZE_W'(1);
      endcase
      send_word(ACT_ALLOC, size, align, junk);
    end else if (r < 85) begin
      idx = $urandom_range(0, live_blocks.size() - 1);
      blk = live_blocks[idx];
      live_blocks.delete(idx);
      send_word(ACT_FREE, blk.units, SIZE_W'($urandom), blk.addr);
    end else begin
      case ($urandom_range(0, 4))
        0: send_word(ACT_FREE, SIZE_W'($urandom), SIZE_W'($urandom), junk);
        1: send_word(ACT_FREE, SIZE_W'($urandom_range(0, 40)), SIZE_W'($urandom), '0);
        2: send_word(ACT_ALLOC, '0, SIZE_W'($urandom), junk);
        3: send_word(ACT_ALLOC, SIZE_W'($urandom), SIZE_W'($urandom), junk);
        // short free anywhere in the map or just past either edge of it
        default: send_word(ACT_FREE, SIZE_W'($urandom_range(1, 24)), SIZE_W'($urandom),
                           ADDR_W'(int'(tracker.base_reg) + int'($urandom_range(0, 4104)) - 8));
      endcase
    end
  endtask

  // random words, then hand back what is still held
  task automatic run_phase(int count);
    live_t blk;
    repeat (count) random_item();
    while (live_blocks.size() != 0) begin
      blk = live_blocks.pop_front();
      send_word(ACT_FREE, blk.units, SIZE_W'($urandom), blk.addr);
    end
    settle();
  endtask

  initial begin
    tracker = new();
    tracker.reset_state();
    items_sent      = 0;
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_action       <= 1'b0;
    in_block_units  <= '0;
    in_alignment    <= '0;
    in_free_address <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_MAP_BASE;
    cfg_wdata       <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words on the reset settings
    send_word(ACT_ALLOC, 13'd1, 13'd1, '0);                 // null unit reserved
    send_word(ACT_ALLOC, 13'd0, 13'd1, '0);                 // zero size fails
    send_word(ACT_ALLOC, 13'd3, 13'd0, '0);                 // zero alignment acts as none
    send_word(ACT_ALLOC, 13'd5, 13'd6, '0);                 // alignment not a power of two
    send_word(ACT_ALLOC, 13'd16, 13'd4096, '0);             // only aligned slot is used
    send_word(ACT_ALLOC, 13'h1FFF, 13'h1FFF, 17'h1FFFF);    // oversized
    send_word(ACT_FREE, 13'd5, 13'd1, '0);                  // address zero ignored
    send_word(ACT_FREE, 13'd0, 13'd1, 17'd2);               // zero size frees nothing
    send_word(ACT_FREE, 13'h1FFF, 13'h1FFF, 17'h1FFFF);     // wholly above the map
    send_word(ACT_FREE, 13'd100, 13'd1, 17'd4090);          // runs past the top
    send_word(ACT_ALLOC, 13'd8, 13'd8, '0);
    send_word(ACT_ALLOC, 13'd64, 13'd64, '0);
    send_word(ACT_FREE, 13'd4095, 13'd1, 17'd1);            // all but the null unit
    send_word(ACT_ALLOC, 13'd4095, 13'd1, '0);              // run ends on the last unit
    send_word(ACT_ALLOC, 13'd1, 13'd1, '0);                 // map full
    send_word(ACT_FREE, 13'd4095, 13'd1, 17'd1);
    send_word(ACT_ALLOC, 13'd4096, 13'd1, '0);              // would need the null unit
    live_blocks.delete();
    run_phase(450);

    // top base, unit count with low bits set
    write_settings(16'hFFFF, 16'd4095, 16'd0);
    send_word(ACT_FREE, 13'd10, 13'd1, 17'h0FFFA);          // starts below the map, frees null
    send_word(ACT_ALLOC, 13'd1, 13'd1, '0);                 // lands on offset zero
    run_phase(350);

    // odd base, tiny map
    write_settings(16'd37, 16'd64, 16'd0);
    run_phase(220);

    // empty map
    write_settings(16'd0, 16'd0, 16'd0);
    run_phase(50);

    // powered down, unit count above the cap
    write_settings(16'd8, 16'h1FFF, 16'd1);
    run_phase(90);

    // random base, all-ones unit data, power bit clear in noisy data
    write_settings(BASE_W'($urandom), 16'hFFFF, 16'hFFFE);
    run_phase(450);

    // smallest map
    write_settings(16'd0, 16'd8, 16'd0);
    run_phase(80);

    // catch stray replies
    repeat (300) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // timeout for a hung run, set well above a search on a badly fragmented map
  initial begin
    #400_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bba_pkg.sv
hdl/bba_ram.sv
hdl/bitmap_block_allocator.sv
hdl/bba_checker.sv
tb/tb.sv
